>>> design/median_priority_queue_core_assert.svh
// Assertion macros shared by the median priority queue RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef MEDIAN_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define MEDIAN_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define MPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mpq_pkg.sv
// Shared types and codes for the median priority queue.
// No dependencies; used by the interfaces, the cell and the top level.
`timescale 1ns / 1ps

package mpq_pkg;

  localparam int unsigned DataW = 32;

  // operation codes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TAKE   = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic                    ins;
    logic                    take;
    logic signed [DataW-1:0] value;
  } cell_ctrl_t;

endpackage

>>> design/mpq_if.sv
// Valid/ready channel interfaces for the median priority queue.
// Depends on mpq_pkg.
`timescale 1ns / 1ps

interface mpq_in_if;
  logic                            valid;
  logic                            ready;
  logic                            operation;
  logic signed [mpq_pkg::DataW-1:0] value;

  modport source (output valid, output operation, output value, input ready);
  modport sink   (input valid, input operation, input value, output ready);
endinterface

interface mpq_out_if #(
  parameter int CntW = 7
);
  logic                            valid;
  logic                            ready;
  logic signed [mpq_pkg::DataW-1:0] median_value;
  logic [1:0]                      status;
  logic [CntW-1:0]                 held_count;

  modport source (output valid, output median_value, output status, output held_count,
                  input ready);
  modport sink   (input valid, input median_value, input status, input held_count,
                  output ready);
endinterface

>>> design/mpq_cell.sv
// One slot of the sorted chain: holds a value, compares it with the
// broadcast value and shifts with its neighbors. Depends on mpq_pkg.
`timescale 1ns / 1ps

module mpq_cell #(
  parameter int IDX  = 0,
  parameter int CntW = 7
) (
  input  logic                             clk_i,
  input  mpq_pkg::cell_ctrl_t              ctrl_i,
  input  logic [CntW-1:0]                  count_i,
  input  logic [CntW-1:0]                  mid_i,
  input  logic                             prev_gt_i,
  input  logic signed [mpq_pkg::DataW-1:0] prev_val_i,
  input  logic signed [mpq_pkg::DataW-1:0] next_val_i,
  output logic                             gt_o,
  output logic signed [mpq_pkg::DataW-1:0] val_o,
  output logic [mpq_pkg::DataW-1:0]        pick_o
);

  localparam logic [CntW-1:0] IdxC     = CntW'(IDX);
  localparam logic [CntW-1:0] IdxNextC = CntW'(IDX + 1);

  logic signed [mpq_pkg::DataW-1:0] val_q, val_d;
  logic                             occupied;

  assign occupied = IdxC < count_i;
  assign gt_o     = occupied && (val_q > ctrl_i.value);
  assign val_o    = val_q;
  assign pick_o   = (IdxC == mid_i) ? val_q : '0;

  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      // values above the insertion point move up by one
      if (prev_gt_i) begin
        val_d = prev_val_i;
      end else if (gt_o || IdxC == count_i) begin
        val_d = ctrl_i.value;
      end
    end else if (ctrl_i.take) begin
      // close the gap left by the median
      if (IdxC >= mid_i && IdxNextC < count_i) begin
        val_d = next_val_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

>>> design/median_priority_queue_core.sv
// Top level of the median priority queue: a chain of sorted cells plus
// the element count and the result register. Depends on mpq_pkg, mpq_if, mpq_cell.
`timescale 1ns / 1ps

// Running lower-median store. Holds up to CAPACITY signed 32-bit values in
// ascending order across a row of cells. An insert transaction places its
// value after any equal values; a take transaction removes and returns the
// element at sorted index (count-1)/2. Each transaction gives one result with
// the status (ok, empty on take, full on insert) and the count afterwards.
// One transaction is accepted per cycle while the result register is empty or
// its result is taken in the same cycle: the insert compare-and-shift and the
// take select-and-shift each finish in the single cell update. The result is
// presented the cycle after acceptance; a stalled result holds off the input.
// Cell contents are not cleared at reset; only the count and the result valid flag are.

module median_priority_queue_core #(
  parameter int CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  mpq_in_if.sink    in_i,
  mpq_out_if.source out_o
);

  `include "median_priority_queue_core_assert.svh"

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int DW   = mpq_pkg::DataW;

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] mid;
  logic            full, empty, acc, ins_en, take_en;

  logic                  out_valid_q, out_valid_d;
  logic signed [DW-1:0]  median_q, median_d;
  logic [1:0]            status_q, status_d;
  logic [CntW-1:0]       held_q;

  mpq_pkg::cell_ctrl_t   ctrl;
  logic                  gt   [CAPACITY];
  logic signed [DW-1:0]  vals [CAPACITY];
  logic [DW-1:0]         picks[CAPACITY];
  logic [DW-1:0]         picked;

  assign full    = count_q == CntW'(CAPACITY);
  assign empty   = count_q == '0;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc     = in_i.valid && in_i.ready;
  assign ins_en  = acc && (in_i.operation == mpq_pkg::OP_INSERT) && !full;
  assign take_en = acc && (in_i.operation == mpq_pkg::OP_TAKE) && !empty;
  assign mid     = (count_q - CntW'(1)) >> 1;

  assign ctrl.ins   = ins_en;
  assign ctrl.take  = take_en;
  assign ctrl.value = in_i.value;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                 prev_gt;
    logic signed [DW-1:0] prev_val, next_val;

    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_mid
      assign prev_gt  = gt[i-1];
      assign prev_val = vals[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = vals[i+1];
    end

    mpq_cell #(
      .IDX  (i),
      .CntW (CntW)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .count_i    (count_q),
      .mid_i      (mid),
      .prev_gt_i  (prev_gt),
      .prev_val_i (prev_val),
      .next_val_i (next_val),
      .gt_o       (gt[i]),
      .val_o      (vals[i]),
      .pick_o     (picks[i])
    );
  end

  // only the cell at the median index drives a nonzero pick
  always_comb begin
    picked = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      picked = picked | picks[i];
    end
  end

  always_comb begin
    count_d  = count_q;
    median_d = '0;
    status_d = mpq_pkg::ST_OK;
    unique case (in_i.operation)
      mpq_pkg::OP_INSERT: begin
        if (full) begin
          status_d = mpq_pkg::ST_FULL;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      mpq_pkg::OP_TAKE: begin
        if (empty) begin
          status_d = mpq_pkg::ST_EMPTY;
        end else begin
          count_d  = count_q - CntW'(1);
          median_d = $signed(picked);
        end
      end
      default: begin
        status_d = mpq_pkg::ST_OK;
      end
    endcase
  end

  always_comb begin
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (acc) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      median_q <= median_d;
      status_q <= status_d;
      held_q   <= count_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.median_value = median_q;
  assign out_o.status       = status_q;
  assign out_o.held_count   = held_q;

  `MPQ_ASSERT_NEXT(a_ins_count, ins_en, count_q == $past(count_q) + CntW'(1), "insert count")
  `MPQ_ASSERT_NEXT(a_take_count, take_en, count_q == $past(count_q) - CntW'(1), "take count")
  `MPQ_ASSERT_NEXT(a_result_count, acc, out_o.valid && held_q == count_q, "result count")
  `MPQ_ASSERT_NOW(a_empty_result, out_valid_q && status_q == mpq_pkg::ST_EMPTY,
                  median_q == '0 && held_q == '0, "empty result")
  `MPQ_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count over capacity")

endmodule
